// ----- sv/sprite_header_resolver_unit_macros.svh -----
// Assertion helpers shared by the resolver RTL.
`ifndef SPRITE_HEADER_RESOLVER_UNIT_MACROS_SVH
`define SPRITE_HEADER_RESOLVER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SHR_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define SHR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/shr_pkg.sv -----
package shr_pkg;

   // Width of store offsets computed during a resolve (entry, frame, frame table).
   localparam int OFS_W = 17;

   localparam logic REQ_WRITE   = 1'b0;
   localparam logic REQ_RESOLVE = 1'b1;

   // Header layout, little-endian.
   localparam int HDR_ADDR       = 0;    // count (+0), header size (+2)
   localparam int RUN_ADDR       = 4;
   localparam int SEC_ADDR       = 8;
   localparam int ENTRY_BASE     = 12;   // 0xC
   localparam int ENTRY_STRIDE   = 12;
   localparam int ENT_ID_BYTES   = 4;
   localparam int ENT_INFO_OFS   = 4;    // frame count (+4), frame offset (+6)
   localparam int ENT_LOOKUP_OFS = 8;
   localparam int ENT_BYTES      = 10;   // 0xA
   localparam int FRAME_STRIDE   = 36;   // 0x24
   localparam int FRAME_DIM_OFS  = 10;   // width (+10), height (+12)
   localparam int FRAME_BYTES    = 14;

   typedef enum logic [2:0] {
      STAT_OK           = 3'd0,
      STAT_NO_HEADER    = 3'd1,
      STAT_EMPTY        = 3'd2,
      STAT_NOT_FOUND    = 3'd3,
      STAT_OUT_OF_STORE = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_HDR,
      S_ENT_CHK,
      S_ENT_WAIT,
      S_INFO,
      S_LKUP,
      S_FRM_CHK,
      S_FRM_WAIT,
      S_RUN,
      S_SEC,
      S_DONE
   } state_type;

   // Loader command: start pulse and byte count minus one.
   typedef struct packed {
      logic       start;
      logic [1:0] len_m1;
   } fetch_cmd_type;

endpackage

// ----- sv/shr_ram.sv -----
module shr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/shr_fetch.sv -----
`include "sprite_header_resolver_unit_macros.svh"

// Byte-serial loader: reads one to four consecutive store bytes, one per
// cycle, and assembles them little-endian into a word.
module shr_fetch import shr_pkg::*; #(
   parameter int ADDR_W = 12
) (
   input  logic              clock,
   input  logic              reset,
   input  fetch_cmd_type     cmd,
   input  logic [ADDR_W-1:0] cmd_addr,
   output logic              rd_en,
   output logic [ADDR_W-1:0] rd_addr,
   input  logic [7:0]        rd_data,
   output logic              done,
   output logic [31:0]       word
);

   logic              busy_ff, busy_in;
   logic              pend_ff, pend_in;
   logic              done_ff, done_in;
   logic [ADDR_W-1:0] base_ff, base_in;
   logic [2:0]        len_ff, len_in;
   logic [2:0]        issue_ff, issue_in;
   logic [2:0]        cap_ff, cap_in;
   logic [31:0]       word_ff, word_in;

   assign rd_en   = busy_ff && (issue_ff < len_ff);
   assign rd_addr = base_ff + ADDR_W'(issue_ff[1:0]);

   always_comb begin
      busy_in  = busy_ff;
      pend_in  = pend_ff;
      done_in  = 1'b0;
      base_in  = base_ff;
      len_in   = len_ff;
      issue_in = issue_ff;
      cap_in   = cap_ff;
      word_in  = word_ff;
      if (cmd.start) begin
         busy_in  = 1'b1;
         pend_in  = 1'b0;
         base_in  = cmd_addr;
         len_in   = {1'b0, cmd.len_m1} + 3'd1;
         issue_in = '0;
         cap_in   = '0;
         word_in  = '0;
      end else if (busy_ff) begin
         pend_in = rd_en;
         if (rd_en) begin
            issue_in = issue_ff + 3'd1;
         end
         if (pend_ff) begin
            word_in[{cap_ff[1:0], 3'b000} +: 8] = rd_data;
            cap_in = cap_ff + 3'd1;
            if (cap_ff + 3'd1 == len_ff) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pend_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         pend_ff <= pend_in;
         done_ff <= done_in;
      end
      base_ff  <= base_in;
      len_ff   <= len_in;
      issue_ff <= issue_in;
      cap_ff   <= cap_in;
      word_ff  <= word_in;
   end

   assign done = done_ff;
   assign word = word_ff;

   `SHR_ASSERT_NOW(a_start_idle, clock, reset, cmd.start, !busy_ff, "fetch started while busy")
   `SHR_ASSERT_NOW(a_done_idle, clock, reset, done_ff, !busy_ff, "fetch done while busy")
   `SHR_ASSERT_NOW(a_cap_bound, clock, reset, pend_ff, cap_ff < len_ff, "byte captured past length")

endmodule

// ----- sv/sprite_header_resolver_unit.sv -----
// Channel   Handshake              Carries
// req       req_valid/req_ready    header byte write or sprite-id resolve
// rsp       rsp_valid/rsp_ready    one result per resolve, none per write
//
// A write leaves the sequencer idle, so the next transaction can be taken right behind it.
// A full resolve reads the header, scans id entries and then frames, and reads the run and
// secondary offsets; each store access goes byte by byte through the single registered read
// port, with a bound check before each entry or frame. Failed resolves stop early.
// Reset is synchronous, active high; it clears the sequencer and rsp_valid. The store has no
// reset. A result waits in the rsp register while the next transaction is taken; a following
// resolve holds in its last step until that register is free.
`include "sprite_header_resolver_unit_macros.svh"

module sprite_header_resolver_unit import shr_pkg::*; #(
   parameter int HEADER_BYTES = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_type,
   input  logic [11:0] req_byte_addr,
   input  logic [7:0]  req_byte_value,
   input  logic [31:0] req_sprite_id,
   input  logic        req_header_present,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic        rsp_resolved,
   output logic [16:0] rsp_frame_table_offset,
   output logic [31:0] rsp_secondary_offset,
   output logic        rsp_secondary_valid,
   output logic [31:0] rsp_run_data_offset,
   output logic [14:0] rsp_max_width,
   output logic [14:0] rsp_max_height,
   output logic [15:0] rsp_frame_count,
   output logic [7:0]  rsp_lookup_byte
);

   localparam int AW = $clog2(HEADER_BYTES);
   localparam logic [OFS_W:0] HB_L = (OFS_W+1)'(HEADER_BYTES);

   // sequencer state and working registers
   state_type          state_ff, state_in;
   status_type         status_ff, status_in;
   logic [31:0]        sid_ff, sid_in;
   logic [15:0]        count_ff, count_in;
   logic [15:0]        hsize_ff, hsize_in;
   logic [15:0]        ent_idx_ff, ent_idx_in;
   logic [OFS_W-1:0]   entry_ff, entry_in;
   logic [15:0]        fcount_ff, fcount_in;
   logic [OFS_W-1:0]   fto_ff, fto_in;
   logic [7:0]         lookup_ff, lookup_in;
   logic [15:0]        frm_idx_ff, frm_idx_in;
   logic [OFS_W-1:0]   frame_ff, frame_in;
   logic signed [15:0] mw_ff, mw_in;
   logic signed [15:0] mh_ff, mh_in;
   logic [31:0]        run_ff, run_in;
   logic [31:0]        sec_ff, sec_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_load;
   status_type         rsp_status_ff;
   logic               rsp_resolved_ff;
   logic [16:0]        rsp_fto_ff;
   logic [31:0]        rsp_sec_ff;
   logic               rsp_sec_valid_ff;
   logic [31:0]        rsp_run_ff;
   logic [14:0]        rsp_mw_ff;
   logic [14:0]        rsp_mh_ff;
   logic [15:0]        rsp_fcount_ff;
   logic [7:0]         rsp_lookup_ff;

   // store and loader
   logic               ram_we;
   logic [AW-1:0]      ram_waddr;
   logic [OFS_W-1:0]   waddr_wide;
   logic               ram_re;
   logic [AW-1:0]      ram_raddr;
   logic [7:0]         ram_rdata;
   fetch_cmd_type      fcmd;
   logic [AW-1:0]      fetch_addr;
   logic               fetch_done;
   logic [31:0]        fetch_word;

   // bounds and addresses
   logic [OFS_W:0]     ent_id_end;
   logic [OFS_W:0]     ent_full_end;
   logic [OFS_W:0]     frm_end;
   logic [OFS_W-1:0]   ent_info_addr;
   logic [OFS_W-1:0]   ent_lk_addr;
   logic [OFS_W-1:0]   frm_dim_addr;
   logic signed [15:0] dim_w;
   logic signed [15:0] dim_h;
   logic               store_ok;

   // assertion helpers
   logic               in_fetch_wait;
   logic               in_frm_chk;
   logic               rsp_failed;
   logic               fail_clean;

   assign req_ready = (state_ff == S_IDLE);

   // writes beyond the store are dropped
   assign waddr_wide = OFS_W'(req_byte_addr);
   assign ram_waddr  = waddr_wide[AW-1:0];
   assign ram_we     = req_valid && req_ready && (req_type == REQ_WRITE) &&
                       ((OFS_W+1)'(req_byte_addr) < HB_L);

   assign ent_id_end    = {1'b0, entry_ff} + (OFS_W+1)'(ENT_ID_BYTES);
   assign ent_full_end  = {1'b0, entry_ff} + (OFS_W+1)'(ENT_BYTES);
   assign frm_end       = {1'b0, frame_ff} + (OFS_W+1)'(FRAME_BYTES);
   assign ent_info_addr = entry_ff + OFS_W'(ENT_INFO_OFS);
   assign ent_lk_addr   = entry_ff + OFS_W'(ENT_LOOKUP_OFS);
   assign frm_dim_addr  = frame_ff + OFS_W'(FRAME_DIM_OFS);
   assign dim_w         = fetch_word[15:0];
   assign dim_h         = fetch_word[31:16];

   shr_ram #(
      .WIDTH (8),
      .DEPTH (HEADER_BYTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (req_byte_value),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   shr_fetch #(
      .ADDR_W (AW)
   ) u_fetch (
      .clock    (clock),
      .reset    (reset),
      .cmd      (fcmd),
      .cmd_addr (fetch_addr),
      .rd_en    (ram_re),
      .rd_addr  (ram_raddr),
      .rd_data  (ram_rdata),
      .done     (fetch_done),
      .word     (fetch_word)
   );

   // sequencer: each loader access is started on the way into its wait state
   always_comb begin
      state_in   = state_ff;
      status_in  = status_ff;
      sid_in     = sid_ff;
      count_in   = count_ff;
      hsize_in   = hsize_ff;
      ent_idx_in = ent_idx_ff;
      entry_in   = entry_ff;
      fcount_in  = fcount_ff;
      fto_in     = fto_ff;
      lookup_in  = lookup_ff;
      frm_idx_in = frm_idx_ff;
      frame_in   = frame_ff;
      mw_in      = mw_ff;
      mh_in      = mh_ff;
      run_in     = run_ff;
      sec_in     = sec_ff;
      fcmd       = '0;
      fetch_addr = '0;
      rsp_load   = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && (req_type == REQ_RESOLVE)) begin
               sid_in    = req_sprite_id;
               status_in = STAT_OK;
               if (!req_header_present) begin
                  status_in = STAT_NO_HEADER;
                  state_in  = S_DONE;
               end else begin
                  fcmd.start  = 1'b1;
                  fcmd.len_m1 = 2'd3;
                  fetch_addr  = AW'(HDR_ADDR);
                  state_in    = S_HDR;
               end
            end
         end
         S_HDR: begin
            if (fetch_done) begin
               count_in   = fetch_word[15:0];
               hsize_in   = fetch_word[31:16];
               ent_idx_in = '0;
               entry_in   = OFS_W'(ENTRY_BASE);
               if (fetch_word[15:0] == 16'd0) begin
                  status_in = STAT_EMPTY;
                  state_in  = S_DONE;
               end else begin
                  state_in = S_ENT_CHK;
               end
            end
         end
         S_ENT_CHK: begin
            if (ent_id_end > HB_L) begin
               status_in = STAT_OUT_OF_STORE;
               state_in  = S_DONE;
            end else begin
               fcmd.start  = 1'b1;
               fcmd.len_m1 = 2'd3;
               fetch_addr  = entry_ff[AW-1:0];
               state_in    = S_ENT_WAIT;
            end
         end
         S_ENT_WAIT: begin
            if (fetch_done) begin
               if (fetch_word == sid_ff) begin
                  if (ent_full_end > HB_L) begin
                     status_in = STAT_OUT_OF_STORE;
                     state_in  = S_DONE;
                  end else begin
                     fcmd.start  = 1'b1;
                     fcmd.len_m1 = 2'd3;
                     fetch_addr  = ent_info_addr[AW-1:0];
                     state_in    = S_INFO;
                  end
               end else if (ent_idx_ff + 16'd1 == count_ff) begin
                  status_in = STAT_NOT_FOUND;
                  state_in  = S_DONE;
               end else begin
                  ent_idx_in = ent_idx_ff + 16'd1;
                  entry_in   = entry_ff + OFS_W'(ENTRY_STRIDE);
                  state_in   = S_ENT_CHK;
               end
            end
         end
         S_INFO: begin
            if (fetch_done) begin
               fcount_in   = fetch_word[15:0];
               fto_in      = OFS_W'(hsize_ff) + OFS_W'(fetch_word[31:16]);
               fcmd.start  = 1'b1;
               fcmd.len_m1 = 2'd0;
               fetch_addr  = ent_lk_addr[AW-1:0];
               state_in    = S_LKUP;
            end
         end
         S_LKUP: begin
            if (fetch_done) begin
               lookup_in  = fetch_word[7:0];
               frm_idx_in = '0;
               frame_in   = fto_ff;
               mw_in      = '0;
               mh_in      = '0;
               state_in   = S_FRM_CHK;
            end
         end
         S_FRM_CHK: begin
            if (frm_idx_ff == fcount_ff) begin
               fcmd.start  = 1'b1;
               fcmd.len_m1 = 2'd3;
               fetch_addr  = AW'(RUN_ADDR);
               state_in    = S_RUN;
            end else if (frm_end > HB_L) begin
               status_in = STAT_OUT_OF_STORE;
               state_in  = S_DONE;
            end else begin
               fcmd.start  = 1'b1;
               fcmd.len_m1 = 2'd3;
               fetch_addr  = frm_dim_addr[AW-1:0];
               state_in    = S_FRM_WAIT;
            end
         end
         S_FRM_WAIT: begin
            if (fetch_done) begin
               if (dim_w > mw_ff) begin
                  mw_in = dim_w;
               end
               if (dim_h > mh_ff) begin
                  mh_in = dim_h;
               end
               frm_idx_in = frm_idx_ff + 16'd1;
               frame_in   = frame_ff + OFS_W'(FRAME_STRIDE);
               state_in   = S_FRM_CHK;
            end
         end
         S_RUN: begin
            if (fetch_done) begin
               run_in      = fetch_word;
               fcmd.start  = 1'b1;
               fcmd.len_m1 = 2'd3;
               fetch_addr  = AW'(SEC_ADDR);
               state_in    = S_SEC;
            end
         end
         S_SEC: begin
            if (fetch_done) begin
               sec_in   = fetch_word;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   assign store_ok = (status_ff == STAT_OK);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      status_ff  <= status_in;
      sid_ff     <= sid_in;
      count_ff   <= count_in;
      hsize_ff   <= hsize_in;
      ent_idx_ff <= ent_idx_in;
      entry_ff   <= entry_in;
      fcount_ff  <= fcount_in;
      fto_ff     <= fto_in;
      lookup_ff  <= lookup_in;
      frm_idx_ff <= frm_idx_in;
      frame_ff   <= frame_in;
      mw_ff      <= mw_in;
      mh_ff      <= mh_in;
      run_ff     <= run_in;
      sec_ff     <= sec_in;
      // failed resolves report zeros in every field but status
      if (rsp_load) begin
         rsp_status_ff    <= status_ff;
         rsp_resolved_ff  <= store_ok;
         rsp_fto_ff       <= store_ok ? fto_ff : '0;
         rsp_sec_ff       <= store_ok ? sec_ff : '0;
         rsp_sec_valid_ff <= store_ok && (sec_ff != 32'd0);
         rsp_run_ff       <= store_ok ? run_ff : '0;
         rsp_mw_ff        <= store_ok ? mw_ff[14:0] : '0;
         rsp_mh_ff        <= store_ok ? mh_ff[14:0] : '0;
         rsp_fcount_ff    <= store_ok ? fcount_ff : '0;
         rsp_lookup_ff    <= store_ok ? lookup_ff : '0;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_status             = rsp_status_ff;
   assign rsp_resolved           = rsp_resolved_ff;
   assign rsp_frame_table_offset = rsp_fto_ff;
   assign rsp_secondary_offset   = rsp_sec_ff;
   assign rsp_secondary_valid    = rsp_sec_valid_ff;
   assign rsp_run_data_offset    = rsp_run_ff;
   assign rsp_max_width          = rsp_mw_ff;
   assign rsp_max_height         = rsp_mh_ff;
   assign rsp_frame_count        = rsp_fcount_ff;
   assign rsp_lookup_byte        = rsp_lookup_ff;

   assign in_fetch_wait = (state_ff == S_HDR) || (state_ff == S_ENT_WAIT) ||
                          (state_ff == S_INFO) || (state_ff == S_LKUP) ||
                          (state_ff == S_FRM_WAIT) || (state_ff == S_RUN) ||
                          (state_ff == S_SEC);
   assign in_frm_chk    = (state_ff == S_FRM_CHK);
   assign rsp_failed    = rsp_valid_ff && (rsp_status_ff != STAT_OK);
   assign fail_clean    = !rsp_resolved_ff && (rsp_fto_ff == '0) &&
                          (rsp_fcount_ff == '0) && (rsp_mw_ff == '0);

   `SHR_ASSERT_NOW(a_done_in_wait, clock, reset, fetch_done, in_fetch_wait, "loader done out of wait")
   `SHR_ASSERT_NOW(a_frame_bound, clock, reset, in_frm_chk, frm_idx_ff <= fcount_ff, "frame index high")
   `SHR_ASSERT_NOW(a_fail_zero, clock, reset, rsp_failed, fail_clean, "failed result carries data")
   `SHR_ASSERT_NEXT(a_load_idle, clock, reset, rsp_load, rsp_valid_ff && req_ready, "load left busy")

endmodule
